FILE: rtl/triangle_point_classifier_unit_defines.svh
// ----------------------------------------------------------------------------
// triangle_point_classifier_unit_defines
// assertion macros shared by the triangle point classifier rtl
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_POINT_CLASSIFIER_UNIT_DEFINES_SVH
`define TRIANGLE_POINT_CLASSIFIER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// property checked while out of reset
`define TPC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tpc assertion failed");

// property checked also across reset
`define TPC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tpc reset assertion failed");

`else

`define TPC_ASSERT(lbl, clk, rst_n, prop)
`define TPC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: rtl/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg
// types and constants of the triangle point classifier
// ----------------------------------------------------------------------------
`default_nettype none

package tpc_pkg;

  // coordinate width of vertices and query points
  localparam int unsigned CoordW = 16;
  localparam int unsigned TolW   = 16;
  // differences, products and sums of two products, all exact
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned ProdW  = 2 * DiffW;
  localparam int unsigned SumW   = ProdW + 1;
  localparam int unsigned CfgW   = (CoordW > TolW) ? CoordW : TolW;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned NumEdges = 3;

  typedef enum logic [CfgAddrW-1:0] {
    RegVertexAX = 3'd0,
    RegVertexAY = 3'd1,
    RegVertexBX = 3'd2,
    RegVertexBY = 3'd3,
    RegVertexCX = 3'd4,
    RegVertexCY = 3'd5,
    RegTolerance = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
  } point_t;

  typedef struct packed {
    logic strictly_inside;
    logic on_boundary;
    logic contained;
  } class_t;

endpackage

`default_nettype wire

FILE: rtl/triangle_point_classifier_unit.sv
// ----------------------------------------------------------------------------
// triangle_point_classifier_unit
// classifies query points against a triangle held in config registers
// ----------------------------------------------------------------------------
// Usage:
// - config port: cfg_we_i writes cfg_wdata_i into register cfg_addr_i
//   (0..5 vertex a/b/c x,y, 6 tolerance); other indexes are dropped.
//   write only while no point is in flight.
// - input channel in_valid_i/in_ready_o carries one query point a beat,
//   output channel out_valid_o/out_ready_i one classification a beat.
// - each input beat passes through the differences, twelve 17x17 products,
//   cross/dot sums and compares into the output register.
// - throughput is one point per cycle while results are taken; each stage has its own valid bit and
//   takes a new beat whenever it is empty or its successor moves on.
// - when the receiver stalls the result holds, the stages behind it fill up
//   and in_ready_o drops once all four are occupied; nothing is lost.
// - reset empties the pipeline, clears vertices to zero and sets the
//   tolerance to one.
// ----------------------------------------------------------------------------
`default_nettype none

`include "triangle_point_classifier_unit_defines.svh"

module triangle_point_classifier_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [tpc_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [tpc_pkg::CfgW-1:0]     cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire tpc_pkg::point_t              in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output tpc_pkg::class_t                   out_data_o
);
  import tpc_pkg::*;

  // configuration
  logic signed [CoordW-1:0] vx_q [NumEdges];
  logic signed [CoordW-1:0] vy_q [NumEdges];
  logic [TolW-1:0]          tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumEdges; k++) begin
        vx_q[k] <= '0;
        vy_q[k] <= '0;
      end
      tol_q <= TolW'(1);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegVertexAX:  vx_q[0] <= cfg_wdata_i[CoordW-1:0];
        RegVertexAY:  vy_q[0] <= cfg_wdata_i[CoordW-1:0];
        RegVertexBX:  vx_q[1] <= cfg_wdata_i[CoordW-1:0];
        RegVertexBY:  vy_q[1] <= cfg_wdata_i[CoordW-1:0];
        RegVertexCX:  vx_q[2] <= cfg_wdata_i[CoordW-1:0];
        RegVertexCY:  vy_q[2] <= cfg_wdata_i[CoordW-1:0];
        RegTolerance: tol_q   <= cfg_wdata_i[TolW-1:0];
        default: ;
      endcase
    end
  end

  // stage handshake
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic s1_ready, s2_ready, s3_ready, out_ready;

  assign out_ready  = !out_valid_q || out_ready_i;
  assign s3_ready   = !s3_valid_q || out_ready;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready)  s1_valid_q  <= in_valid_i;
      if (s2_ready)  s2_valid_q  <= s1_valid_q;
      if (s3_ready)  s3_valid_q  <= s2_valid_q;
      if (out_ready) out_valid_q <= s3_valid_q;
    end
  end

  // stage 1: point offsets from each vertex and edge vectors
  logic signed [DiffW-1:0] dpx_d [NumEdges];
  logic signed [DiffW-1:0] dpy_d [NumEdges];
  logic signed [DiffW-1:0] ex_d  [NumEdges];
  logic signed [DiffW-1:0] ey_d  [NumEdges];
  logic signed [DiffW-1:0] dpx_q [NumEdges];
  logic signed [DiffW-1:0] dpy_q [NumEdges];
  logic signed [DiffW-1:0] ex_q  [NumEdges];
  logic signed [DiffW-1:0] ey_q  [NumEdges];

  always_comb begin
    for (int k = 0; k < NumEdges; k++) begin
      dpx_d[k] = DiffW'(in_data_i.point_x) - DiffW'(vx_q[k]);
      dpy_d[k] = DiffW'(in_data_i.point_y) - DiffW'(vy_q[k]);
      ex_d[k]  = DiffW'(vx_q[(k + 1) % NumEdges]) - DiffW'(vx_q[k]);
      ey_d[k]  = DiffW'(vy_q[(k + 1) % NumEdges]) - DiffW'(vy_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      dpx_q <= dpx_d;
      dpy_q <= dpy_d;
      ex_q  <= ex_d;
      ey_q  <= ey_d;
    end
  end

  // stage 2: exact products
  // edge k: cross = ex*dpy - ey*dpx, dot = dpx_k*dpx_k+1 + dpy_k*dpy_k+1
  logic signed [ProdW-1:0] m_ey_d [NumEdges];
  logic signed [ProdW-1:0] m_ex_d [NumEdges];
  logic signed [ProdW-1:0] m_dx_d [NumEdges];
  logic signed [ProdW-1:0] m_dy_d [NumEdges];
  logic signed [ProdW-1:0] m_ey_q [NumEdges];
  logic signed [ProdW-1:0] m_ex_q [NumEdges];
  logic signed [ProdW-1:0] m_dx_q [NumEdges];
  logic signed [ProdW-1:0] m_dy_q [NumEdges];

  always_comb begin
    for (int k = 0; k < NumEdges; k++) begin
      m_ey_d[k] = ProdW'(ex_q[k]) * ProdW'(dpy_q[k]);
      m_ex_d[k] = ProdW'(ey_q[k]) * ProdW'(dpx_q[k]);
      m_dx_d[k] = ProdW'(dpx_q[k]) * ProdW'(dpx_q[(k + 1) % NumEdges]);
      m_dy_d[k] = ProdW'(dpy_q[k]) * ProdW'(dpy_q[(k + 1) % NumEdges]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      m_ey_q <= m_ey_d;
      m_ex_q <= m_ex_d;
      m_dx_q <= m_dx_d;
      m_dy_q <= m_dy_d;
    end
  end

  // stage 3: cross and dot sums
  logic signed [SumW-1:0] cross_d [NumEdges];
  logic signed [SumW-1:0] dot_d   [NumEdges];
  logic signed [SumW-1:0] cross_q [NumEdges];
  logic signed [SumW-1:0] dot_q   [NumEdges];

  always_comb begin
    for (int k = 0; k < NumEdges; k++) begin
      cross_d[k] = SumW'(m_ey_q[k]) - SumW'(m_ex_q[k]);
      dot_d[k]   = SumW'(m_dx_q[k]) + SumW'(m_dy_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      cross_q <= cross_d;
      dot_q   <= dot_d;
    end
  end

  // stage 4: tolerance compares into the output register
  logic signed [SumW-1:0] tol_pos, tol_neg;
  logic [NumEdges-1:0]    above, below, near;
  logic                   all_pos, all_neg, boundary;
  class_t                 out_d, out_q;

  assign tol_pos = $signed({{(SumW - TolW){1'b0}}, tol_q});
  assign tol_neg = -tol_pos;

  always_comb begin
    for (int k = 0; k < NumEdges; k++) begin
      above[k] = cross_q[k] > tol_pos;
      below[k] = cross_q[k] < tol_neg;
      near[k]  = (cross_q[k] < tol_pos) && (cross_q[k] > tol_neg) && (dot_q[k] <= tol_pos);
    end
    all_pos  = &above;
    all_neg  = &below;
    boundary = |near;
    out_d.strictly_inside = all_pos || all_neg;
    out_d.on_boundary     = boundary;
    out_d.contained       = all_pos || all_neg || boundary;
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s3_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `TPC_ASSERT(a_contained_is_or, clk_i, rst_ni,
    out_valid_o |-> (out_data_o.contained ==
                     (out_data_o.strictly_inside || out_data_o.on_boundary)))
  `TPC_ASSERT(a_stall_only_when_full, clk_i, rst_ni,
    !in_ready_o |-> (out_valid_o && !out_ready_i && s1_valid_q && s2_valid_q && s3_valid_q))
  `TPC_ASSERT(a_sides_exclusive, clk_i, rst_ni,
    s3_valid_q |-> !(all_pos && all_neg))
  `TPC_ASSERT(a_zero_tol_no_boundary, clk_i, rst_ni,
    (s3_valid_q && (tol_q == '0)) |-> !boundary)
  `TPC_ASSERT_ALWAYS(a_reset_empties_output, clk_i,
    !rst_ni |=> !out_valid_o)

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// testbench of the triangle point classifier: query points are sent against
// directed and random triangles and tolerances, and each classification is
// checked against a cycle-free predictor while both sides idle and stall
// ----------------------------------------------------------------------------
module tb;
  import tpc_pkg::*;

  localparam int unsigned HalfPeriod = 6;
  localparam int unsigned ResetCycles = 12;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned HoldCycles = 40;
  localparam int unsigned CycleLimit = 200000;
  // index past the last register, writes there must be dropped
  localparam logic [CfgAddrW-1:0] RegUnused = 3'd7;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [CfgW-1:0]     cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  point_t              in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  class_t              out_data_o;

  // shadow of the triangle registers
  logic signed [CoordW-1:0] vert_x [3];
  logic signed [CoordW-1:0] vert_y [3];
  logic [TolW-1:0]          tol_reg;

  class_t expected_class_q [$];

  int unsigned cycle_cnt;
  int unsigned err_cnt;
  int unsigned point_cnt;
  int unsigned setup_cnt;
  int unsigned checked_cnt;
  int unsigned inside_cnt;
  int unsigned boundary_cnt;

  // sender pacing
  bit pace_on;
  int burst_left;

  // receiver control
  bit stall_req;
  bit rx_free;
  int rx_mode;
  int rx_left;
  int unsigned rx_phase;

  triangle_point_classifier_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial clk_i = 1'b0;
  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("triangle_point_classifier_unit: mismatch");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // exact edge tests; 64-bit signed holds every product and sum
  function automatic class_t classify_point(input point_t p);
    longint vx [3];
    longint vy [3];
    longint px, py, tol, sx, sy, ex, ey, cr, dt;
    bit all_pos, all_neg, edge_hit;
    class_t r;
    int k;
    for (k = 0; k < 3; k++) begin
      vx[k] = vert_x[k];
      vy[k] = vert_y[k];
    end
    px = p.point_x;
    py = p.point_y;
    tol = longint'({48'd0, tol_reg});
    all_pos = 1'b1;
    all_neg = 1'b1;
    edge_hit = 1'b0;
    for (k = 0; k < 3; k++) begin
      sx = vx[k];
      sy = vy[k];
      ex = vx[(k + 1) % 3];
      ey = vy[(k + 1) % 3];
      cr = (ex - sx) * (py - sy) - (ey - sy) * (px - sx);
      dt = (px - sx) * (px - ex) + (py - sy) * (py - ey);
      if (!(cr > tol)) all_pos = 1'b0;
      if (!(cr < -tol)) all_neg = 1'b0;
      if (cr < tol && cr > -tol && dt <= tol) edge_hit = 1'b1;
    end
    r.strictly_inside = all_pos | all_neg;
    r.on_boundary = edge_hit;
    r.contained = all_pos | all_neg | edge_hit;
    return r;
  endfunction

  function automatic logic signed [CoordW-1:0] clamp_coord(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[CoordW-1:0];
  endfunction

  function automatic point_t mk_point(input int x, input int y);
    point_t p;
    p.point_x = clamp_coord(x);
    p.point_y = clamp_coord(y);
    return p;
  endfunction

  // ---- result checker ------------------------------------------------------
  always @(posedge clk_i) begin
    class_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_class_q.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected: %b", out_data_o));
      end else begin
        want = expected_class_q.pop_front();
        checked_cnt++;
        if (want.strictly_inside) inside_cnt++;
        if (want.on_boundary) boundary_cnt++;
        if (out_data_o.strictly_inside !== want.strictly_inside)
          report_mismatch($sformatf("strictly_inside got %b want %b",
                                    out_data_o.strictly_inside, want.strictly_inside));
        if (out_data_o.on_boundary !== want.on_boundary)
          report_mismatch($sformatf("on_boundary got %b want %b",
                                    out_data_o.on_boundary, want.on_boundary));
        if (out_data_o.contained !== want.contained)
          report_mismatch($sformatf("contained got %b want %b",
                                    out_data_o.contained, want.contained));
      end
    end
  end

  // ---- receiver ------------------------------------------------------------
  initial begin
    out_ready_i = 1'b0;
    stall_req = 1'b0;
    rx_free = 1'b0;
    rx_left = 0;
    rx_phase = 0;
  end

  always @(negedge clk_i) begin
    if (stall_req) begin
      // long hold-off so the pipeline fills and in_ready_o drops
      out_ready_i = 1'b0;
      repeat (HoldCycles) @(negedge clk_i);
      stall_req = 1'b0;
      out_ready_i = 1'b1;
    end else if (rx_free) begin
      out_ready_i = 1'b1;
    end else begin
      if (rx_left <= 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(8, 64);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
        0: out_ready_i = 1'b1;
        1: out_ready_i = $urandom_range(0, 1);
        2: out_ready_i = (rx_phase % 4) != 0;
        default: out_ready_i = ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // ---- sender and config ---------------------------------------------------
  task automatic send_point(input point_t p);
    int gap;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i = p;
    do @(posedge clk_i); while (!in_ready_o);
    expected_class_q.push_back(classify_point(p));
    point_cnt++;
    if (pace_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        gap = $urandom_range(1, 6);
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
        burst_left = $urandom_range(1, 20);
      end
    end
  endtask

  // stop offering points until every classification is back
  task automatic drain_pipe();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_class_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_addr_i = addr;
    cfg_wdata_i = val;
    @(posedge clk_i);
    case (addr)
      RegVertexAX: vert_x[0] = val;
      RegVertexAY: vert_y[0] = val;
      RegVertexBX: vert_x[1] = val;
      RegVertexBY: vert_y[1] = val;
      RegVertexCX: vert_x[2] = val;
      RegVertexCY: vert_y[2] = val;
      RegTolerance: tol_reg = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_triangle(input int ax, input int ay, input int bx, input int by,
                              input int cx, input int cy, input int tol);
    drain_pipe();
    write_reg(RegVertexAX, clamp_coord(ax));
    write_reg(RegVertexAY, clamp_coord(ay));
    write_reg(RegVertexBX, clamp_coord(bx));
    write_reg(RegVertexBY, clamp_coord(by));
    write_reg(RegVertexCX, clamp_coord(cx));
    write_reg(RegVertexCY, clamp_coord(cy));
    write_reg(RegTolerance, tol[TolW-1:0]);
    setup_cnt++;
  endtask

  // mostly points near the triangle or on its edges, some anywhere
  function automatic point_t pick_point();
    int xmin, xmax, ymin, ymax, k, t, sel;
    xmin = vert_x[0]; xmax = vert_x[0];
    ymin = vert_y[0]; ymax = vert_y[0];
    for (k = 1; k < 3; k++) begin
      if (vert_x[k] < xmin) xmin = vert_x[k];
      if (vert_x[k] > xmax) xmax = vert_x[k];
      if (vert_y[k] < ymin) ymin = vert_y[k];
      if (vert_y[k] > ymax) ymax = vert_y[k];
    end
    sel = $urandom_range(0, 99);
    k = $urandom_range(0, 2);
    if (sel < 45) begin
      return mk_point(xmin - 8 + int'($urandom_range(0, xmax - xmin + 16)),
                      ymin - 8 + int'($urandom_range(0, ymax - ymin + 16)));
    end else if (sel < 60) begin
      return mk_point(vert_x[k] + int'($urandom_range(0, 2)) - 1,
                      vert_y[k] + int'($urandom_range(0, 2)) - 1);
    end else if (sel < 80) begin
      t = $urandom_range(0, 8);
      return mk_point(vert_x[k] + (vert_x[(k + 1) % 3] - vert_x[k]) * t / 8,
                      vert_y[k] + (vert_y[(k + 1) % 3] - vert_y[k]) * t / 8);
    end else begin
      return mk_point(int'($signed($urandom_range(0, 65535) - 32768)),
                      int'($signed($urandom_range(0, 65535) - 32768)));
    end
  endfunction

  // ---- tests ---------------------------------------------------------------
  task automatic test_reset_values();
    // all vertices at the origin, tolerance one
    send_point(mk_point(0, 0));
    send_point(mk_point(1, 0));
    send_point(mk_point(1, 1));
    send_point(mk_point(-32768, 32767));
  endtask

  task automatic test_directed();
    // counter-clockwise right triangle
    set_triangle(0, 0, 100, 0, 0, 100, 1);
    send_point(mk_point(10, 10));
    send_point(mk_point(50, 0));
    send_point(mk_point(100, 0));
    send_point(mk_point(60, 60));
    send_point(mk_point(-1, 50));
    send_point(mk_point(32767, 32767));
    send_point(mk_point(-32768, -32768));
    // clockwise: all crosses negative
    set_triangle(0, 0, 0, 100, 100, 0, 1);
    send_point(mk_point(10, 10));
    send_point(mk_point(0, 50));
    // zero tolerance: edge points are not on the boundary
    drain_pipe();
    write_reg(RegTolerance, '0);
    send_point(mk_point(0, 50));
    send_point(mk_point(20, 20));
    // index past the register file is dropped
    drain_pipe();
    write_reg(RegUnused, '1);
    send_point(mk_point(0, 0));
    // triangle spanning the whole coordinate range, widest tolerance
    set_triangle(-32768, -32768, 32767, -32768, -32768, 32767, 65535);
    send_point(mk_point(32767, 32767));
    send_point(mk_point(-32768, -32768));
    send_point(mk_point(0, 0));
    send_point(mk_point(32767, -32768));
    send_point(mk_point(-1, -1));
    // collinear vertices, then coincident ones
    set_triangle(-10, -10, 0, 0, 10, 10, 4);
    send_point(mk_point(5, 5));
    send_point(mk_point(5, 6));
    set_triangle(7, -3, 7, -3, 7, -3, 2);
    send_point(mk_point(7, -3));
    send_point(mk_point(8, -3));
  endtask

  task automatic test_random_triangles(input int setups, input int per_setup);
    int s, n, kind, cx0, cy0, dx, dy, tol;
    int v [6];
    for (s = 0; s < setups; s++) begin
      kind = $urandom_range(0, 3);
      cx0 = int'($urandom_range(0, 2000)) - 1000;
      cy0 = int'($urandom_range(0, 2000)) - 1000;
      for (n = 0; n < 6; n++) begin
        case (kind)
          0: v[n] = ((n % 2) ? cy0 : cx0) + int'($urandom_range(0, 600)) - 300;
          1: v[n] = int'($urandom_range(0, 65535)) - 32768;
          2: v[n] = 0;
          default: v[n] = $urandom_range(0, 1) ? 32767 : -32768;
        endcase
      end
      if (kind == 2) begin
        dx = int'($urandom_range(0, 400)) - 200;
        dy = int'($urandom_range(0, 400)) - 200;
        v = '{cx0, cy0, cx0 + dx, cy0 + dy, cx0 + 2 * dx, cy0 + 2 * dy};
      end
      case ($urandom_range(0, 4))
        0: tol = 0;
        1: tol = 65535;
        2: tol = 1;
        3: tol = $urandom_range(0, 500);
        default: tol = $urandom_range(0, 65535);
      endcase
      set_triangle(v[0], v[1], v[2], v[3], v[4], v[5], tol);
      for (n = 0; n < per_setup; n++) send_point(pick_point());
    end
  endtask

  task automatic test_backpressure();
    int n;
    set_triangle(-200, -150, 250, -100, 20, 300, 40);
    pace_on = 1'b0;
    stall_req = 1'b1;
    for (n = 0; n < 30; n++) send_point(pick_point());
    // sender waits for every result before going on
    drain_pipe();
    pace_on = 1'b1;
    for (n = 0; n < 30; n++) send_point(pick_point());
  endtask

  task automatic test_full_rate();
    int n;
    pace_on = 1'b0;
    rx_free = 1'b1;
    for (n = 0; n < 60; n++) send_point(pick_point());
    rx_free = 1'b0;
    pace_on = 1'b1;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = RegVertexAX;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    for (int k = 0; k < 3; k++) begin
      vert_x[k] = '0;
      vert_y[k] = '0;
    end
    tol_reg = 1;
    cycle_cnt = 0;
    err_cnt = 0;
    point_cnt = 0;
    setup_cnt = 0;
    checked_cnt = 0;
    inside_cnt = 0;
    boundary_cnt = 0;
    pace_on = 1'b1;
    burst_left = $urandom_range(1, 20);
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_values();
    test_directed();
    test_random_triangles(10, 60);
    test_backpressure();
    test_full_rate();

    drain_pipe();
    if (expected_class_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_class_q.size()));
    $display("ran %0d points over %0d triangle setups, %0d results checked",
             point_cnt, setup_cnt, checked_cnt);
    $display("%0d strictly inside, %0d on an edge", inside_cnt, boundary_cnt);
    if (err_cnt == 0) begin
      $display("triangle_point_classifier_unit: match");
    end else begin
      $display("triangle_point_classifier_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/tpc_pkg.sv
rtl/triangle_point_classifier_unit.sv
bench/tb.sv
